/* rtl/core/nhpm_pkg.sv */
package nhpm_pkg;

    localparam int NHPM_NODE_COUNT = 64;

    localparam int CNT_W   = 8;
    localparam int CMD_W   = 3;
    localparam int IDX_W   = 6;
    localparam int CODE_W  = 2;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_REG   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLR_ONE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLR_ALL   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd4;

    localparam logic [CODE_W-1:0] EV_RESTORED = 2'd0;
    localparam logic [CODE_W-1:0] EV_LOST     = 2'd1;
    localparam logic [CODE_W-1:0] EV_BOTH     = 2'd2;

    localparam logic [2:0] CFG_COUNT_TOP    = 3'd0;
    localparam logic [2:0] CFG_ONLINE_MIN   = 3'd1;
    localparam logic [2:0] CFG_OFFLINE_MIN  = 3'd2;
    localparam logic [2:0] CFG_REC_INTERVAL = 3'd3;
    localparam logic [2:0] CFG_LOSS_INTERVAL = 3'd4;

    localparam logic [CNT_W-1:0] RST_COUNT_TOP     = 8'd255;
    localparam logic [CNT_W-1:0] RST_ONLINE_MIN    = 8'd3;
    localparam logic [CNT_W-1:0] RST_OFFLINE_MIN   = 8'd1;
    localparam logic [CNT_W-1:0] RST_REC_INTERVAL  = 8'd5;
    localparam logic [CNT_W-1:0] RST_LOSS_INTERVAL = 8'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_SWEEP_RD,
        S_SWEEP_EV,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic             registered;
        logic             offline;
        logic [CNT_W-1:0] count;
    } t_node;

    typedef struct packed {
        logic rec;
        logic loss;
    } t_pass;

    typedef struct packed {
        logic              changed;
        logic [CODE_W-1:0] code;
        logic              offline;
        logic              clr_count;
    } t_eval;

endpackage

/* rtl/core/nhpm_eval.sv */
module nhpm_eval
    import nhpm_pkg::*;
(
    input  t_node            i_node,
    input  t_pass            i_pass,
    input  logic [CNT_W-1:0] i_online_min,
    input  logic [CNT_W-1:0] i_offline_min,
    output t_eval            o_eval
);

    logic enough;
    logic too_few;

    assign enough  = i_node.count >= i_online_min;
    assign too_few = i_node.count < i_offline_min;

    always_comb begin
        o_eval.changed   = 1'b0;
        o_eval.code      = EV_RESTORED;
        o_eval.offline   = i_node.offline;
        o_eval.clr_count = i_pass.loss && i_node.registered;

        // recovery pass
        if (i_pass.rec && i_node.offline && enough) begin
            o_eval.offline = 1'b0;
            o_eval.changed = 1'b1;
        end

        // loss pass, registered nodes only
        if (i_pass.loss && i_node.registered) begin
            if (!o_eval.offline && too_few) begin
                o_eval.offline = 1'b1;
                o_eval.code    = o_eval.changed ? EV_BOTH : EV_LOST;
                o_eval.changed = 1'b1;
            end else if (o_eval.offline && enough) begin
                o_eval.offline = 1'b0;
                o_eval.changed = 1'b1;
                o_eval.code    = EV_RESTORED;
            end
        end
    end

endmodule

/* rtl/core/node_heartbeat_presence_monitor.sv */
// node heartbeat presence monitor
// input channel (i_in_valid / o_in_stall) takes one command beat: heartbeat,
// set registration, clear one count, clear all counts or tick. the output
// channel (o_out_valid / i_out_stall) gives one event beat per node whose
// presence changed during a tick, in ascending node order, o_last on the final.
// node state sits in two single-port memories (flags and counts), read data
// registered; heartbeat, set registration, clear one and each tick node are a
// read-modify-write over those ports. heartbeat, set registration, clear one:
// read in idle, write in the modify state. clear all, unknown command and
// out-of-range index: handled in idle. tick: one read and one write-back per
// node, then a flush; a waiting event on a stalled output holds the sweep;
// input is stalled for the whole sweep. the last event leaves at sweep end.
// reset clears the per-entry valid bits, so every entry reads its reset value
// at once; there is no clearing pass. config registers return to defaults.
// a stalled output holds its beat; input beats are still taken meanwhile.
// config: apb writes at 4*index, pready always high.
module node_heartbeat_presence_monitor
    import nhpm_pkg::*;
#(
    parameter int NODE_COUNT = NHPM_NODE_COUNT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [IDX_W-1:0]   i_panel_index,
    input  logic               i_register_value,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [IDX_W-1:0]   o_event_index,
    output logic [CODE_W-1:0]  o_event_code,
    output logic               o_last,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NODE_COUNT - 1);
    localparam logic [IDX_W:0] NODE_LIM = (IDX_W + 1)'(NODE_COUNT);

    typedef struct packed {
        logic registered;
        logic offline;
    } t_flags;

    // config
    logic [CNT_W-1:0] r_count_top;
    logic [CNT_W-1:0] r_online_min;
    logic [CNT_W-1:0] r_offline_min;
    logic [CNT_W-1:0] r_rec_interval;
    logic [CNT_W-1:0] r_loss_interval;
    logic             cfg_wr;

    // control
    t_state           r_state;
    t_state           n_state;
    logic [CMD_W-1:0] r_cmd;
    logic             r_regv;
    logic [AW-1:0]    r_addr;
    logic [CNT_W-1:0] r_rec_ticks;
    logic [CNT_W-1:0] r_loss_ticks;
    t_pass            r_pass;

    // memories
    t_flags           r_st_mem  [NODE_COUNT];
    logic [CNT_W-1:0] r_cnt_mem [NODE_COUNT];
    logic [NODE_COUNT-1:0] r_st_vld;
    logic [NODE_COUNT-1:0] r_cnt_vld;
    t_flags           r_st_q;
    logic             r_st_qv;
    logic [CNT_W-1:0] r_cnt_q;
    logic             r_cnt_qv;

    // pending and output beats
    logic              r_pend_valid;
    logic [AW-1:0]     r_pend_idx;
    logic [CODE_W-1:0] r_pend_code;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_idx;
    logic [CODE_W-1:0] r_out_code;
    logic              r_out_last;

    // combinational control
    logic             accept;
    logic             in_range;
    logic             out_free;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             st_we;
    t_flags           st_wdata;
    logic             cnt_we;
    logic [CNT_W-1:0] cnt_wdata;
    logic             cnt_clr_all;
    logic             ev_step;
    logic             pend_load;
    logic             out_load;
    logic             out_last_in;
    logic             sweep_done;

    // tick counters
    logic [CNT_W-1:0] rec_inc;
    logic [CNT_W-1:0] loss_inc;
    logic             rec_hit;
    logic             loss_hit;

    t_node            node;
    t_eval            ev;
    logic             rst_registered;

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_top     <= RST_COUNT_TOP;
            r_online_min    <= RST_ONLINE_MIN;
            r_offline_min   <= RST_OFFLINE_MIN;
            r_rec_interval  <= RST_REC_INTERVAL;
            r_loss_interval <= RST_LOSS_INTERVAL;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                CFG_COUNT_TOP:     r_count_top     <= pwdata[CNT_W-1:0];
                CFG_ONLINE_MIN:    r_online_min    <= pwdata[CNT_W-1:0];
                CFG_OFFLINE_MIN:   r_offline_min   <= pwdata[CNT_W-1:0];
                CFG_REC_INTERVAL:  r_rec_interval  <= pwdata[CNT_W-1:0];
                CFG_LOSS_INTERVAL: r_loss_interval <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            CFG_COUNT_TOP:     prdata = PDATA_W'(r_count_top);
            CFG_ONLINE_MIN:    prdata = PDATA_W'(r_online_min);
            CFG_OFFLINE_MIN:   prdata = PDATA_W'(r_offline_min);
            CFG_REC_INTERVAL:  prdata = PDATA_W'(r_rec_interval);
            CFG_LOSS_INTERVAL: prdata = PDATA_W'(r_loss_interval);
            default:           prdata = '0;
        endcase
    end

    // ---------------- read data with reset values ----------------
    assign rst_registered = ((IDX_W + 1)'(r_addr) == (IDX_W + 1)'(1))
                         || ((IDX_W + 1)'(r_addr) == (IDX_W + 1)'(2));

    always_comb begin
        node.registered = r_st_qv ? r_st_q.registered : rst_registered;
        node.offline    = r_st_qv ? r_st_q.offline    : 1'b0;
        node.count      = r_cnt_qv ? r_cnt_q : '0;
    end

    nhpm_eval u_eval (
        .i_node        (node),
        .i_pass        (r_pass),
        .i_online_min  (r_online_min),
        .i_offline_min (r_offline_min),
        .o_eval        (ev)
    );

    // ---------------- control ----------------
    assign in_range   = {1'b0, i_panel_index} < NODE_LIM;
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign sweep_done = r_addr == LAST_ADDR;

    assign rec_inc  = r_rec_ticks + 1'b1;
    assign loss_inc = r_loss_ticks + 1'b1;
    assign rec_hit  = rec_inc >= r_rec_interval;
    assign loss_hit = loss_inc >= r_loss_interval;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_cmd)
                        CMD_HEARTBEAT, CMD_SET_REG, CMD_CLR_ONE: begin
                            if (in_range) begin
                                n_state = S_MOD;
                            end
                        end
                        CMD_TICK: n_state = S_SWEEP_RD;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_MOD:      n_state = S_IDLE;
            S_SWEEP_RD: n_state = S_SWEEP_EV;
            S_SWEEP_EV: begin
                if (ev_step) begin
                    n_state = sweep_done ? S_FLUSH : S_SWEEP_RD;
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = r_state != S_IDLE;
        rd_en       = 1'b0;
        rd_addr     = r_addr;
        st_we       = 1'b0;
        st_wdata    = '{registered: node.registered, offline: node.offline};
        cnt_we      = 1'b0;
        cnt_wdata   = node.count;
        cnt_clr_all = 1'b0;
        ev_step     = 1'b0;
        pend_load   = 1'b0;
        out_load    = 1'b0;
        out_last_in = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                rd_addr = i_panel_index[AW-1:0];
                if (i_in_valid) begin
                    unique case (i_cmd)
                        CMD_HEARTBEAT, CMD_SET_REG, CMD_CLR_ONE: rd_en = in_range;
                        CMD_CLR_ALL: cnt_clr_all = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_MOD: begin
                unique case (r_cmd)
                    CMD_HEARTBEAT: begin
                        cnt_we = 1'b1;
                        if (node.count < r_count_top) begin
                            cnt_wdata = node.count + 1'b1;
                        end
                    end
                    CMD_SET_REG: begin
                        st_we             = 1'b1;
                        st_wdata.registered = r_regv;
                    end
                    CMD_CLR_ONE: begin
                        cnt_we    = 1'b1;
                        cnt_wdata = '0;
                    end
                    default: ;
                endcase
            end
            S_SWEEP_RD: rd_en = 1'b1;
            S_SWEEP_EV: begin
                ev_step = !ev.changed || !r_pend_valid || out_free;
                if (ev_step) begin
                    st_we            = 1'b1;
                    st_wdata.offline = ev.offline;
                    cnt_we           = ev.clr_count;
                    cnt_wdata        = '0;
                    pend_load        = ev.changed;
                    out_load         = ev.changed && r_pend_valid;
                end
            end
            S_FLUSH: begin
                out_load    = r_pend_valid && out_free;
                out_last_in = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cmd        <= CMD_HEARTBEAT;
            r_regv       <= 1'b0;
            r_addr       <= '0;
            r_rec_ticks  <= '0;
            r_loss_ticks <= '0;
            r_pass       <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cmd  <= i_cmd;
                r_regv <= i_register_value;
                if (i_cmd == CMD_TICK) begin
                    r_addr       <= '0;
                    r_pass.rec   <= rec_hit;
                    r_pass.loss  <= loss_hit;
                    r_rec_ticks  <= (rec_hit || loss_hit) ? '0 : rec_inc;
                    r_loss_ticks <= loss_hit ? '0 : loss_inc;
                end else begin
                    r_addr <= i_panel_index[AW-1:0];
                end
            end else if (ev_step && !sweep_done) begin
                r_addr <= r_addr + 1'b1;
            end
        end
    end

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_st_mem[r_addr] <= st_wdata;
        end
        if (rd_en) begin
            r_st_q <= r_st_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[r_addr] <= cnt_wdata;
        end
        if (rd_en) begin
            r_cnt_q <= r_cnt_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_vld  <= '0;
            r_cnt_vld <= '0;
            r_st_qv   <= 1'b0;
            r_cnt_qv  <= 1'b0;
        end else begin
            if (st_we) begin
                r_st_vld[r_addr] <= 1'b1;
            end
            if (cnt_clr_all) begin
                r_cnt_vld <= '0;
            end else if (cnt_we) begin
                r_cnt_vld[r_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_st_qv  <= r_st_vld[rd_addr];
                r_cnt_qv <= r_cnt_vld[rd_addr];
            end
        end
    end

    // ---------------- pending event and output beat ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (pend_load) begin
                r_pend_valid <= 1'b1;
            end else if (out_load) begin
                r_pend_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_load) begin
            r_pend_idx  <= r_addr;
            r_pend_code <= ev.code;
        end
        if (out_load) begin
            r_out_idx  <= IDX_W'(r_pend_idx);
            r_out_code <= r_pend_code;
            r_out_last <= out_last_in;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_index = r_out_idx;
    assign o_event_code  = r_out_code;
    assign o_last        = r_out_last;

endmodule

/* rtl/core/nhpm_checker.sv */
module nhpm_checker
    import nhpm_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [CMD_W-1:0]  i_cmd,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [IDX_W-1:0]  o_event_index,
    input logic [CODE_W-1:0] o_event_code,
    input logic              o_last
);

    // no beat right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat right after reset");

    // a tick starts a sweep, so the next beat waits
    a_tick_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_cmd == CMD_TICK) |=> o_in_stall)
        else $error("input taken during a sweep");

    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_event_code == EV_RESTORED || o_event_code == EV_LOST
                         || o_event_code == EV_BOTH))
        else $error("illegal event code");

    // events are only produced while a sweep is running or flushing
    a_event_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("event outside a sweep");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_event_index)
                                          && $stable(o_event_code) && $stable(o_last)))
        else $error("stalled beat changed");

endmodule

bind node_heartbeat_presence_monitor nhpm_checker u_nhpm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_cmd         (i_cmd),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_event_index (o_event_index),
    .o_event_code  (o_event_code),
    .o_last        (o_last)
);
